// File: rtl/tkm_pkg.sv
// ============================================================================
// tkm_pkg
// Shared types, codes and defaults of the per-column top-K match merge.
// ============================================================================
`default_nettype none

package tkm_pkg;

    localparam int NUM_COLUMNS_DEF = 1024;
    localparam int TOP_SLOTS_DEF   = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_REGS   = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OVERFLOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAXM      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_OFF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COL_OFF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEF_THR   = 3'd4;

    // request commands
    localparam logic [1:0] CMD_MERGE = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef enum logic [2:0] {
        OUT_SKIP  = 3'd0,
        OUT_INS   = 3'd1,
        OUT_EVICT = 3'd2,
        OUT_RAISE = 3'd3,
        OUT_CLEAR = 3'd4,
        OUT_READ  = 3'd5
    } outcome_t;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_MOD,
        ST_CRD,
        ST_CDEC,
        ST_SCAN,
        ST_SDEC,
        ST_RWAIT,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// File: rtl/tkm_if.sv
// ============================================================================
// tkm_if
// Request and response channel interfaces of the top-K match merge.
// ============================================================================
`default_nettype none

interface tkm_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] corr;
    logic [31:0]        row;
    logic [9:0]         col;
    logic [2:0]         slot;

    modport source (output valid, cmd, corr, row, col, slot, input ready);
    modport sink   (input valid, cmd, corr, row, col, slot, output ready);
endinterface

interface tkm_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         outcome;
    logic signed [31:0] threshold_now;
    logic               slot_valid;
    logic signed [31:0] slot_corr;
    logic [31:0]        slot_row;

    modport source (output valid, outcome, threshold_now, slot_valid, slot_corr, slot_row,
                    input ready);
    modport sink   (input valid, outcome, threshold_now, slot_valid, slot_corr, slot_row,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/per_column_top_k_match_merge.sv
// ============================================================================
// per_column_top_k_match_merge
// Per-column top-K match store with adaptive column thresholds.
// ============================================================================
// Usage:
//   req carries one command per request: merge a match, clear a column, or
//   read one slot. rsp returns exactly one result per request (outcome, the
//   column threshold after the command, and slot contents for a read).
//   cfg_we/cfg_idx/cfg_wdata write the configuration registers; write them
//   only while no request is in flight. A write to a known register ends the current group.
//   Flow: one request at a time. Clear, read of an empty slot, overflow-mode
//   merges and skipped merges pass through the column wrap steps, the column
//   RAM read, its decode and the emit state; a read of a used slot adds an
//   entry RAM read. A normal-mode merge scans every slot of the column through
//   the entry RAM read port, one slot per cycle, then decides and emits.
//   The column wrap reduces the column index modulo NUM_COLUMNS in restoring
//   steps, one subtraction of a shifted NUM_COLUMNS per step.
//   Reset: a sweep writes every column RAM row to zero threshold and empty
//   slots, during which req.ready stays low.
//   Stall: the result sits in an output register; the next request is taken
//   while it waits, and the block holds its next result until rsp drains.
// ============================================================================
`default_nettype none

module per_column_top_k_match_merge
    import tkm_pkg::*;
#(
    parameter int NUM_COLUMNS = NUM_COLUMNS_DEF,
    parameter int TOP_SLOTS   = TOP_SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    tkm_req_if.sink               req,
    tkm_rsp_if.source             rsp
);

    localparam int CW        = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam int SW        = (TOP_SLOTS > 1) ? $clog2(TOP_SLOTS) : 1;
    localparam int CNW       = $clog2(TOP_SLOTS + 1);
    localparam int EDEPTH    = NUM_COLUMNS * (2 ** SW);
    localparam int CMW       = 32 + TOP_SLOTS;
    localparam int SUM_MAX   = 2046;
    localparam int QMAX      = SUM_MAX / NUM_COLUMNS;
    localparam int MOD_STEPS = (QMAX > 0) ? $clog2(QMAX + 1) : 0;

    // control state
    state_t state_reg, state_next;
    logic [CW-1:0] sweep_reg, sweep_next;
    logic [3:0]    mstep_reg, mstep_next;

    // captured request
    logic [1:0]         cmd_reg, cmd_next;
    logic signed [31:0] corr_reg, corr_next;
    logic [31:0]        row_reg, row_next;
    logic [2:0]         slot_reg, slot_next;
    logic [10:0]        val_reg, val_next;

    // configuration
    logic               ovf_reg, ovf_next;
    logic [3:0]         maxm_reg, maxm_next;
    logic [31:0]        rowoff_reg, rowoff_next;
    logic [9:0]         coloff_reg, coloff_next;
    logic signed [31:0] dthr_reg, dthr_next;

    // group tracking
    logic               gact_reg, gact_next;
    logic [9:0]         gcol_reg, gcol_next;
    logic [3:0]         gpos_reg, gpos_next;
    logic               gstop_reg, gstop_next;
    logic signed [31:0] pend_reg, pend_next;

    // column row copy and scan
    logic signed [31:0]   thr_reg, thr_next;
    logic [TOP_SLOTS-1:0] mask_reg, mask_next;
    logic [CNW-1:0]       icnt_reg, icnt_next;
    logic                 pv_reg, pv_next;
    logic [SW-1:0]        pidx_reg, pidx_next;
    logic [CNW-1:0]       ucnt_reg, ucnt_next;
    logic                 hmin_reg, hmin_next;
    logic signed [31:0]   min_reg, min_next;
    logic [SW-1:0]        mslot_reg, mslot_next;
    logic                 ffound_reg, ffound_next;
    logic [SW-1:0]        fslot_reg, fslot_next;

    // staged and output result
    outcome_t           so_reg, so_next;
    logic signed [31:0] sthr_reg, sthr_next;
    logic               ssv_reg, ssv_next;
    logic signed [31:0] scorr_reg, scorr_next;
    logic [31:0]        srow_reg, srow_next;
    logic               ov_reg, ov_next;
    outcome_t           oo_reg, oo_next;
    logic signed [31:0] othr_reg, othr_next;
    logic               osv_reg, osv_next;
    logic signed [31:0] ocorr_reg, ocorr_next;
    logic [31:0]        orow_reg, orow_next;

    // memory ports
    logic                 cm_we, cm_re;
    logic [CW-1:0]        cm_waddr, cm_raddr;
    logic [CMW-1:0]       cm_wdata, cm_rdata;
    logic                 em_we, em_re;
    logic [CW+SW-1:0]     em_waddr, em_raddr;
    logic [63:0]          em_wdata, em_rdata;

    logic [CW-1:0]        cidx;
    logic signed [31:0]   rd_thr;
    logic [TOP_SLOTS-1:0] rd_mask;
    logic signed [31:0]   ecorr;
    logic [7:0]           lim8, pos8;
    logic [3:0]           pos_bump;
    logic [31:0]          modsub;
    logic                 accept;

    // column RAM: threshold above the slot occupancy mask
    tkm_ram #(.WIDTH(CMW), .DEPTH(NUM_COLUMNS)) u_colmem (
        .clk   (clk),
        .we    (cm_we),
        .waddr (cm_waddr),
        .wdata (cm_wdata),
        .re    (cm_re),
        .raddr (cm_raddr),
        .rdata (cm_rdata)
    );

    // entry RAM: correlation above absolute row, addressed {column, slot}
    tkm_ram #(.WIDTH(64), .DEPTH(EDEPTH)) u_entmem (
        .clk   (clk),
        .we    (em_we),
        .waddr (em_waddr),
        .wdata (em_wdata),
        .re    (em_re),
        .raddr (em_raddr),
        .rdata (em_rdata)
    );

    assign cidx     = CW'(val_reg);
    assign rd_thr   = cm_rdata[TOP_SLOTS +: 32];
    assign rd_mask  = cm_rdata[TOP_SLOTS-1:0];
    assign ecorr    = em_rdata[63:32];
    assign lim8     = ({4'b0, maxm_reg} > 8'(TOP_SLOTS)) ? 8'(TOP_SLOTS) : {4'b0, maxm_reg};
    assign pos8     = {4'b0, gpos_reg};
    assign pos_bump = (gpos_reg == 4'hF) ? 4'hF : gpos_reg + 4'd1;
    assign modsub   = 32'(NUM_COLUMNS) << mstep_reg;
    assign accept   = req.valid && req.ready;

    assign req.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = ov_reg;
    assign rsp.outcome       = oo_reg;
    assign rsp.threshold_now = othr_reg;
    assign rsp.slot_valid    = osv_reg;
    assign rsp.slot_corr     = ocorr_reg;
    assign rsp.slot_row      = orow_reg;

    always_comb
    begin
        logic [TOP_SLOTS-1:0] newmask;

        state_next  = state_reg;
        sweep_next  = sweep_reg;
        mstep_next  = mstep_reg;
        cmd_next    = cmd_reg;
        corr_next   = corr_reg;
        row_next    = row_reg;
        slot_next   = slot_reg;
        val_next    = val_reg;
        ovf_next    = ovf_reg;
        maxm_next   = maxm_reg;
        rowoff_next = rowoff_reg;
        coloff_next = coloff_reg;
        dthr_next   = dthr_reg;
        gact_next   = gact_reg;
        gcol_next   = gcol_reg;
        gpos_next   = gpos_reg;
        gstop_next  = gstop_reg;
        pend_next   = pend_reg;
        thr_next    = thr_reg;
        mask_next   = mask_reg;
        icnt_next   = icnt_reg;
        pv_next     = pv_reg;
        pidx_next   = pidx_reg;
        ucnt_next   = ucnt_reg;
        hmin_next   = hmin_reg;
        min_next    = min_reg;
        mslot_next  = mslot_reg;
        ffound_next = ffound_reg;
        fslot_next  = fslot_reg;
        so_next     = so_reg;
        sthr_next   = sthr_reg;
        ssv_next    = ssv_reg;
        scorr_next  = scorr_reg;
        srow_next   = srow_reg;
        ov_next     = ov_reg;
        oo_next     = oo_reg;
        othr_next   = othr_reg;
        osv_next    = osv_reg;
        ocorr_next  = ocorr_reg;
        orow_next   = orow_reg;

        newmask  = mask_reg;
        newmask[fslot_reg] = 1'b1;

        cm_we    = 1'b0;
        cm_waddr = cidx;
        cm_wdata = {thr_reg, mask_reg};
        cm_re    = 1'b0;
        cm_raddr = cidx;
        em_we    = 1'b0;
        em_waddr = {cidx, fslot_reg};
        em_wdata = {corr_reg, row_reg + rowoff_reg};
        em_re    = 1'b0;
        em_raddr = {cidx, SW'(slot_reg)};

        // configuration writes; a known register ends the group
        if (cfg_we)
        begin
            case (cfg_idx)
                REG_OVERFLOW: ovf_next    = cfg_wdata[0];
                REG_MAXM:     maxm_next   = cfg_wdata[3:0];
                REG_ROW_OFF:  rowoff_next = cfg_wdata;
                REG_COL_OFF:  coloff_next = cfg_wdata[9:0];
                REG_DEF_THR:  dthr_next   = cfg_wdata;
                default:      ;
            endcase
            if (32'(cfg_idx) < NUM_REGS)
            begin
                gact_next  = 1'b0;
                gpos_next  = 4'd0;
                gstop_next = 1'b0;
            end
        end

        // drain the output register
        if (ov_reg && rsp.ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_SWEEP:
            begin
                cm_we    = 1'b1;
                cm_waddr = sweep_reg;
                cm_wdata = '0;
                if (sweep_reg == CW'(NUM_COLUMNS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = req.cmd;
                    corr_next = req.corr;
                    row_next  = req.row;
                    slot_next = req.slot;
                    if (req.cmd == CMD_MERGE)
                    begin
                        val_next = {1'b0, req.col} + {1'b0, coloff_reg};
                        // a new column opens a new group
                        if (!gact_reg || gcol_reg != req.col)
                        begin
                            gact_next  = 1'b1;
                            gcol_next  = req.col;
                            gpos_next  = 4'd0;
                            gstop_next = 1'b0;
                        end
                    end
                    else
                    begin
                        val_next = {1'b0, req.col};
                    end
                    mstep_next = 4'(MOD_STEPS - 1);
                    state_next = (MOD_STEPS == 0) ? ST_CRD : ST_MOD;
                end
            end

            ST_MOD:
            begin
                // one restoring step of the column wrap per cycle
                if ({21'b0, val_reg} >= modsub)
                begin
                    val_next = val_reg - 11'(modsub);
                end
                if (mstep_reg == 4'd0)
                begin
                    state_next = ST_CRD;
                end
                else
                begin
                    mstep_next = mstep_reg - 4'd1;
                end
            end

            ST_CRD:
            begin
                cm_re      = 1'b1;
                state_next = ST_CDEC;
            end

            ST_CDEC:
            begin
                thr_next   = rd_thr;
                mask_next  = rd_mask;
                so_next    = OUT_SKIP;
                sthr_next  = rd_thr;
                ssv_next   = 1'b0;
                scorr_next = '0;
                srow_next  = '0;
                state_next = ST_EMIT;
                case (cmd_reg)
                    CMD_MERGE:
                    begin
                        if (ovf_reg)
                        begin
                            if (pos8 == lim8)
                            begin
                                pend_next = corr_reg;
                            end
                            else if (pos8 == lim8 + 8'd1 && rd_thr < pend_reg)
                            begin
                                cm_we     = 1'b1;
                                cm_wdata  = {pend_reg, rd_mask};
                                so_next   = OUT_RAISE;
                                sthr_next = pend_reg;
                            end
                            gpos_next = pos_bump;
                        end
                        else if (!gstop_reg && pos8 < lim8)
                        begin
                            icnt_next   = '0;
                            pv_next     = 1'b0;
                            ucnt_next   = '0;
                            hmin_next   = 1'b0;
                            ffound_next = 1'b0;
                            state_next  = ST_SCAN;
                        end
                    end

                    CMD_CLEAR:
                    begin
                        cm_we     = 1'b1;
                        cm_wdata  = {dthr_reg, {TOP_SLOTS{1'b0}}};
                        so_next   = OUT_CLEAR;
                        sthr_next = dthr_reg;
                    end

                    CMD_READ:
                    begin
                        so_next = OUT_READ;
                        if (32'(slot_reg) < TOP_SLOTS && rd_mask[SW'(slot_reg)])
                        begin
                            em_re      = 1'b1;
                            state_next = ST_RWAIT;
                        end
                    end

                    default: ;
                endcase
            end

            ST_SCAN:
            begin
                // fold the slot whose data returned this cycle
                if (pv_reg)
                begin
                    if (mask_reg[pidx_reg])
                    begin
                        ucnt_next = ucnt_reg + 1'b1;
                        if (!hmin_reg || ecorr < min_reg)
                        begin
                            hmin_next  = 1'b1;
                            min_next   = ecorr;
                            mslot_next = pidx_reg;
                        end
                    end
                    else if (!ffound_reg)
                    begin
                        ffound_next = 1'b1;
                        fslot_next  = pidx_reg;
                    end
                end
                // issue the next slot read
                if (icnt_reg < CNW'(TOP_SLOTS))
                begin
                    em_re     = 1'b1;
                    em_raddr  = {cidx, SW'(icnt_reg)};
                    pv_next   = 1'b1;
                    pidx_next = SW'(icnt_reg);
                    icnt_next = icnt_reg + 1'b1;
                end
                else
                begin
                    pv_next = 1'b0;
                    if (!pv_reg)
                    begin
                        state_next = ST_SDEC;
                    end
                end
            end

            ST_SDEC:
            begin
                state_next = ST_EMIT;
                if (8'(ucnt_reg) >= lim8)
                begin
                    if (!hmin_reg || corr_reg <= min_reg)
                    begin
                        gstop_next = 1'b1;
                    end
                    else
                    begin
                        // evict the minimum; it becomes the threshold
                        em_we     = 1'b1;
                        em_waddr  = {cidx, mslot_reg};
                        cm_we     = 1'b1;
                        cm_wdata  = {min_reg, mask_reg};
                        so_next   = OUT_EVICT;
                        sthr_next = min_reg;
                        gpos_next = pos_bump;
                    end
                end
                else if (ffound_reg)
                begin
                    em_we     = 1'b1;
                    cm_we     = 1'b1;
                    cm_wdata  = {thr_reg, newmask};
                    so_next   = OUT_INS;
                    gpos_next = pos_bump;
                end
            end

            ST_RWAIT:
            begin
                ssv_next   = 1'b1;
                scorr_next = em_rdata[63:32];
                srow_next  = em_rdata[31:0];
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                // hold the result until the output register is free
                if (!ov_reg || rsp.ready)
                begin
                    ov_next    = 1'b1;
                    oo_next    = so_reg;
                    othr_next  = sthr_reg;
                    osv_next   = ssv_reg;
                    ocorr_next = scorr_reg;
                    orow_next  = srow_reg;
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_SWEEP;
            sweep_reg  <= '0;
            ovf_reg    <= 1'b0;
            maxm_reg   <= 4'd8;
            rowoff_reg <= '0;
            coloff_reg <= '0;
            dthr_reg   <= '0;
            gact_reg   <= 1'b0;
            gcol_reg   <= '0;
            gpos_reg   <= '0;
            gstop_reg  <= 1'b0;
            pend_reg   <= '0;
            pv_reg     <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            ovf_reg    <= ovf_next;
            maxm_reg   <= maxm_next;
            rowoff_reg <= rowoff_next;
            coloff_reg <= coloff_next;
            dthr_reg   <= dthr_next;
            gact_reg   <= gact_next;
            gcol_reg   <= gcol_next;
            gpos_reg   <= gpos_next;
            gstop_reg  <= gstop_next;
            pend_reg   <= pend_next;
            pv_reg     <= pv_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mstep_reg  <= mstep_next;
        cmd_reg    <= cmd_next;
        corr_reg   <= corr_next;
        row_reg    <= row_next;
        slot_reg   <= slot_next;
        val_reg    <= val_next;
        thr_reg    <= thr_next;
        mask_reg   <= mask_next;
        icnt_reg   <= icnt_next;
        pidx_reg   <= pidx_next;
        ucnt_reg   <= ucnt_next;
        hmin_reg   <= hmin_next;
        min_reg    <= min_next;
        mslot_reg  <= mslot_next;
        ffound_reg <= ffound_next;
        fslot_reg  <= fslot_next;
        so_reg     <= so_next;
        sthr_reg   <= sthr_next;
        ssv_reg    <= ssv_next;
        scorr_reg  <= scorr_next;
        srow_reg   <= srow_next;
        oo_reg     <= oo_next;
        othr_reg   <= othr_next;
        osv_reg    <= osv_next;
        ocorr_reg  <= ocorr_next;
        orow_reg   <= orow_next;
    end

endmodule

`default_nettype wire

// File: rtl/tkm_ram.sv
// ============================================================================
// tkm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
`default_nettype none

module tkm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/tkm_checker.sv
// ============================================================================
// tkm_checker
// Port-level checks of the top-K match merge, bound to the top level.
// ============================================================================
`default_nettype none

module tkm_checker
    import tkm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  rsp_outcome,
    input logic        rsp_slot_valid,
    input logic [31:0] rsp_slot_corr,
    input logic [31:0] rsp_slot_row
);

    // hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // one request in flight: no request taken in the cycle after one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

    a_slot_only_read: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_slot_valid |-> rsp_outcome == OUT_READ)
        else $error("slot contents on a non-read response");

    a_empty_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_slot_valid |-> rsp_slot_corr == 32'd0 && rsp_slot_row == 32'd0)
        else $error("empty slot reports nonzero contents");

endmodule

bind per_column_top_k_match_merge tkm_checker u_tkm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_outcome    (rsp.outcome),
    .rsp_slot_valid (rsp.slot_valid),
    .rsp_slot_corr  (rsp.slot_corr),
    .rsp_slot_row   (rsp.slot_row)
);

`default_nettype wire
